// File: rtl/sdn_pkg.sv
// Shared types, widths and constant tables for the scale-degree to note block.
package sdn_pkg;

  // Musical constants
  localparam int SEMITONES_PER_OCTAVE = 12;
  localparam int MAX_DEGREES          = 12;

  // Field widths
  localparam int IDX_W     = 12;
  localparam int NOTE_W    = 16;
  localparam int BASE_W    = 7;
  localparam int SIZE_W    = 4;
  localparam int OFS_W     = 4;
  localparam int OFFSETS_W = 48;

  // Divider widths: the biased index is non-negative and below 2**U_W
  localparam int U_W         = IDX_W + SIZE_W - 1;
  localparam int RECIP_SHIFT = U_W + SIZE_W;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int PROD_W      = U_W + RECIP_W;
  localparam int IDX_BIAS    = 2 ** (IDX_W - 1);

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_BASE_NOTE     = 2'd0,
    REG_SCALE_SIZE    = 2'd1,
    REG_SCALE_OFFSETS = 2'd2
  } cfg_reg_e;

  // Divider result handed to the note stage
  typedef struct packed {
    logic                     valid;
    logic signed [NOTE_W-1:0] octave;
    logic [SIZE_W-1:0]        degree;
  } div_res_t;

  // Clamp the raw scale size to 1..MAX_DEGREES
  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] raw);
    logic [SIZE_W-1:0] s;
    s = raw;
    if (s == '0) s = SIZE_W'(1);
    if (s > SIZE_W'(MAX_DEGREES)) s = SIZE_W'(MAX_DEGREES);
    return s;
  endfunction

  // ceil(2**RECIP_SHIFT / s): exact floor quotient for any dividend below 2**U_W
  function automatic logic [RECIP_W-1:0] recip(input logic [SIZE_W-1:0] s);
    logic [RECIP_W-1:0] r;
    unique case (s)
      4'd1:    r = RECIP_W'(524288);
      4'd2:    r = RECIP_W'(262144);
      4'd3:    r = RECIP_W'(174763);
      4'd4:    r = RECIP_W'(131072);
      4'd5:    r = RECIP_W'(104858);
      4'd6:    r = RECIP_W'(87382);
      4'd7:    r = RECIP_W'(74899);
      4'd8:    r = RECIP_W'(65536);
      4'd9:    r = RECIP_W'(58255);
      4'd10:   r = RECIP_W'(52429);
      4'd11:   r = RECIP_W'(47663);
      4'd12:   r = RECIP_W'(43691);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/sdn_floor_div.sv
// Three-stage pipelined floor divider: octave and non-negative degree of a signed index.
module sdn_floor_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  input  logic signed [sdn_pkg::IDX_W-1:0]    index_i,
  input  logic [sdn_pkg::SIZE_W-1:0]          size_i,
  output sdn_pkg::div_res_t                   res_o
);
  import sdn_pkg::*;

  // Stage A: bias the index by size * IDX_BIAS so it is never negative
  logic              a_valid_q;
  logic [U_W-1:0]    a_u_q, a_u_d;
  logic [SIZE_W-1:0] a_size_q;

  // Stage B: multiply by the reciprocal
  logic              b_valid_q;
  logic [PROD_W-1:0] b_prod_q, b_prod_d;
  logic [U_W-1:0]    b_u_q;
  logic [SIZE_W-1:0] b_size_q;

  // Stage C: quotient, remainder and octave
  logic                     c_valid_q;
  logic signed [NOTE_W-1:0] c_oct_q, c_oct_d;
  logic [SIZE_W-1:0]        c_deg_q, c_deg_d;
  logic [SIZE_W-1:0]        c_size_q;

  logic [U_W-1:0] idx_ext;
  logic [U_W-1:0] bias;
  logic [U_W-1:0] quot;
  logic [U_W-1:0] qs;
  logic [U_W-1:0] rem;

  always_comb begin
    idx_ext = {{(U_W-IDX_W){index_i[IDX_W-1]}}, index_i};
    bias    = {size_i, {(IDX_W-1){1'b0}}};
    a_u_d   = idx_ext + bias;
  end

  assign b_prod_d = PROD_W'(a_u_q) * PROD_W'(recip(a_size_q));

  always_comb begin
    quot    = b_prod_q[RECIP_SHIFT +: U_W];
    qs      = U_W'(quot * U_W'(b_size_q));
    rem     = b_u_q - qs;
    c_deg_d = rem[SIZE_W-1:0];
    c_oct_d = NOTE_W'(quot) - NOTE_W'(IDX_BIAS);
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else begin
      a_valid_q <= valid_i;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
    end
  end

  // Advance payload; the size travels with each word
  always_ff @(posedge clk_i) begin
    a_u_q    <= a_u_d;
    a_size_q <= size_i;
    b_prod_q <= b_prod_d;
    b_u_q    <= a_u_q;
    b_size_q <= a_size_q;
    c_oct_q  <= c_oct_d;
    c_deg_q  <= c_deg_d;
    c_size_q <= b_size_q;
  end

  assign res_o.valid  = c_valid_q;
  assign res_o.octave = c_oct_q;
  assign res_o.degree = c_deg_q;

  // The remainder is always below the divisor it was computed with
  a_deg_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_valid_q && c_size_q != '0 |-> c_deg_q < c_size_q)
    else $error("degree not below scale size");

  // Every result comes from a word that entered stages A, B and C in turn
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_valid_q |-> $past(valid_i, 3))
    else $error("result without matching input");

  // Octave stays within the span of the index field
  a_oct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_valid_q && c_size_q != '0 |->
      (c_oct_q >= $signed(NOTE_W'(-IDX_BIAS))) &&
      (c_oct_q <= $signed(NOTE_W'(IDX_BIAS - 1))))
    else $error("octave out of range");

endmodule

// File: rtl/scale_degree_to_note.sv
// Top level: configuration registers, floor divider and note assembly stage.
//
// Channel   Direction  Handshake                   Payload
// command   in         start_i (busy_o always low) degree_index_i
// result    out        done_o strobe, one cycle    note_number_o
// config    in         cfg_valid_i / cfg_ready_o   cfg_index_i, cfg_data_i
//
// One word enters every cycle; each result passes through the divider stages,
// bias, reciprocal multiply and remainder, then one stage for octave scaling,
// offset lookup and the final add.
// Reset restores base note 60, scale size 7 and the major-scale offsets.
// No stall exists: results are strobed and must be taken when shown.
module scale_degree_to_note (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  output logic                                   busy_o,
  input  logic signed [sdn_pkg::IDX_W-1:0]       degree_index_i,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [1:0]                             cfg_index_i,
  input  logic [sdn_pkg::OFFSETS_W-1:0]          cfg_data_i,
  output logic                                   done_o,
  output logic signed [sdn_pkg::NOTE_W-1:0]      note_number_o
);
  import sdn_pkg::*;

  logic [BASE_W-1:0]    base_note_q;
  logic [SIZE_W-1:0]    scale_size_q;
  logic [OFFSETS_W-1:0] scale_offsets_q;
  logic [SIZE_W-1:0]    size_eff;
  div_res_t             div_res;

  logic [OFS_W-1:0]     ofs [MAX_DEGREES];
  logic [OFS_W-1:0]     offset;
  logic [NOTE_W-1:0]    oct12;
  logic [NOTE_W-1:0]    note_d;
  logic [NOTE_W-1:0]    note_q;
  logic                 done_q;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  // Write configuration registers; unknown indexes drop the word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_note_q     <= BASE_W'(60);
      scale_size_q    <= SIZE_W'(7);
      scale_offsets_q <= OFFSETS_W'(48'h0000_0B97_5420);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_BASE_NOTE:     base_note_q     <= cfg_data_i[BASE_W-1:0];
        REG_SCALE_SIZE:    scale_size_q    <= cfg_data_i[SIZE_W-1:0];
        REG_SCALE_OFFSETS: scale_offsets_q <= cfg_data_i;
        default:           ;
      endcase
    end
  end

  assign size_eff = eff_size(scale_size_q);

  sdn_floor_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i && !busy_o),
    .index_i (degree_index_i),
    .size_i  (size_eff),
    .res_o   (div_res)
  );

  // Unpack the semitone offsets
  always_comb begin
    for (int i = 0; i < MAX_DEGREES; i++) begin
      ofs[i] = scale_offsets_q[i*OFS_W +: OFS_W];
    end
  end

  // Scale the octave, look up the degree offset and add the base
  always_comb begin
    offset = (div_res.degree < SIZE_W'(MAX_DEGREES)) ? ofs[div_res.degree] : '0;
    oct12  = NOTE_W'(div_res.octave * NOTE_W'(SEMITONES_PER_OCTAVE));
    note_d = NOTE_W'(base_note_q) + oct12 + NOTE_W'(offset);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= div_res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    note_q <= note_d;
  end

  assign done_o        = done_q;
  assign note_number_o = note_q;

  // Every accepted word is answered by a done_o strobe
  a_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##4 done_o)
    else $error("accepted word not answered");

  // No result without an earlier start
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, 4))
    else $error("result without a start");

  // Note stage strobes done in the cycle after the divider result
  a_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(div_res.valid))
    else $error("note stage out of step with divider");

endmodule

// File: tb/scale_degree_to_note_test.sv
// Self-checking testbench for scale_degree_to_note: floor-divide note mapping.
module scale_degree_to_note_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sdn_pkg::*;

  // Unused register index: writes to it must leave every register alone
  localparam logic [1:0] REG_SPARE = 2'd3;
  // Cycles that cover the block's four pipeline stages with some margin
  localparam int DRAIN_CYCLES = 8;
  localparam int RAND_PHASES  = 9;
  localparam int PHASE_WORDS  = 200;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        start_i = 1'b0;
  logic                        busy_o;
  logic signed [IDX_W-1:0]     degree_index_i = '0;
  logic                        cfg_valid_i = 1'b0;
  logic                        cfg_ready_o;
  logic [1:0]                  cfg_index_i = '0;
  logic [OFFSETS_W-1:0]        cfg_data_i = '0;
  logic                        done_o;
  logic signed [NOTE_W-1:0]    note_number_o;

  // Degrees waiting to be driven and notes waiting to come out
  logic signed [IDX_W-1:0]     pending_degrees[$];
  logic signed [NOTE_W-1:0]    expected_notes[$];

  // Shadow copy of the configuration registers
  logic [BASE_W-1:0]           cur_base;
  logic [SIZE_W-1:0]           cur_size;
  logic [OFFSETS_W-1:0]        cur_offsets;

  logic                        word_taken = 1'b0;
  logic                        cfg_taken = 1'b0;
  logic                        steady = 1'b0;
  int                          errors = 0;
  logic signed [NOTE_W-1:0]    want_note;

  scale_degree_to_note u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .degree_index_i (degree_index_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .done_o         (done_o),
    .note_number_o  (note_number_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Floor-divide the degree by the clamped scale size and build the note
  function automatic logic signed [NOTE_W-1:0] predict_note(input logic signed [IDX_W-1:0] idx);
    int sz;
    int octave;
    int degree;
    int sum;
    sz = int'(cur_size);
    if (sz == 0) sz = 1;
    if (sz > MAX_DEGREES) sz = MAX_DEGREES;
    octave = int'(idx) / sz;
    degree = int'(idx) % sz;
    if (degree < 0) begin
      degree += sz;
      octave -= 1;
    end
    sum = int'(cur_base) + octave * SEMITONES_PER_OCTAVE
        + int'((cur_offsets >> (4 * degree)) & 48'hF);
    return NOTE_W'(sum);
  endfunction

  function automatic logic [OFFSETS_W-1:0] rand_word();
    return OFFSETS_W'({$urandom, $urandom});
  endfunction

  // Append one degree to the drive queue
  task automatic queue_degree(input logic signed [IDX_W-1:0] d);
    pending_degrees.insert(pending_degrees.size(), d);
  endtask

  // Drive one degree per handshake, idling at random unless in a steady stretch
  always @(negedge clk_i) begin
    if (rst_ni && (!start_i || word_taken)) begin
      if (pending_degrees.size() != 0 && (steady || $urandom_range(99) >= 12)) begin
        start_i        <= 1'b1;
        degree_index_i <= pending_degrees.pop_front();
      end else begin
        start_i        <= 1'b0;
        degree_index_i <= IDX_W'($urandom);
      end
    end
  end

  // Track accepted words and config writes, check every strobed note
  always @(posedge clk_i) begin
    word_taken <= rst_ni && start_i && !busy_o;
    cfg_taken  <= rst_ni && cfg_valid_i && cfg_ready_o;
    if (!rst_ni) begin
      cur_base    = BASE_W'(60);
      cur_size    = SIZE_W'(7);
      cur_offsets = OFFSETS_W'(48'hB975420);
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_BASE_NOTE:     cur_base    = cfg_data_i[BASE_W-1:0];
          REG_SCALE_SIZE:    cur_size    = cfg_data_i[SIZE_W-1:0];
          REG_SCALE_OFFSETS: cur_offsets = cfg_data_i;
          default: ;
        endcase
      end
      if (start_i && !busy_o) begin
        expected_notes.insert(expected_notes.size(), predict_note(degree_index_i));
      end
      if (done_o) begin
        if (expected_notes.size() == 0) begin
          $display("%0t: note_number expected none actual %0d", $time, note_number_o);
          errors++;
        end else begin
          want_note = expected_notes.pop_front();
          if (note_number_o !== want_note) begin
            $display("%0t: note_number expected %0d actual %0d",
                     $time, want_note, note_number_o);
            errors++;
          end
        end
      end
    end
  end

  // Write one register while the block is idle
  task automatic write_reg(input logic [1:0] idx, input logic [OFFSETS_W-1:0] data);
    if (!steady && $urandom_range(99) < 12) repeat ($urandom_range(1, 4)) @(negedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(negedge clk_i); while (!cfg_taken);
    cfg_valid_i <= 1'b0;
    cfg_index_i <= 2'($urandom);
    cfg_data_i  <= rand_word();
  endtask

  // Hold until every pending word is driven and every note has come back
  task automatic wait_drained();
    do begin
      @(negedge clk_i);
      #1;
    end while (pending_degrees.size() != 0 || start_i || expected_notes.size() != 0);
  endtask

  initial begin
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset scale: octave edges in both directions and the index extremes
    queue_degree(IDX_W'(0));
    queue_degree(IDX_W'(6));
    queue_degree(IDX_W'(7));
    queue_degree(IDX_W'(-1));
    queue_degree(IDX_W'(-7));
    queue_degree(IDX_W'(-8));
    queue_degree(IDX_W'(2047));
    queue_degree(IDX_W'(-2048));
    wait_drained();

    // Lowest settings, upper data bits set to check masking
    write_reg(REG_BASE_NOTE, {rand_word() | ~OFFSETS_W'(8'h7F)} & ~OFFSETS_W'(8'h7F));
    write_reg(REG_SCALE_SIZE, (rand_word() & ~OFFSETS_W'(4'hF)) | OFFSETS_W'(1));
    write_reg(REG_SCALE_OFFSETS, '0);
    queue_degree(IDX_W'(-2048));
    queue_degree(IDX_W'(2047));
    queue_degree(IDX_W'(0));
    queue_degree(IDX_W'(-1));
    wait_drained();

    // Highest settings
    write_reg(REG_BASE_NOTE, OFFSETS_W'(127));
    write_reg(REG_SCALE_SIZE, OFFSETS_W'(12));
    write_reg(REG_SCALE_OFFSETS, '1);
    queue_degree(IDX_W'(-2048));
    queue_degree(IDX_W'(2047));
    queue_degree(IDX_W'(11));
    queue_degree(IDX_W'(12));
    queue_degree(IDX_W'(-12));
    queue_degree(IDX_W'(-13));
    wait_drained();

    // Size zero acts as one
    write_reg(REG_SCALE_SIZE, OFFSETS_W'(0));
    write_reg(REG_SCALE_OFFSETS, rand_word());
    queue_degree(IDX_W'(5));
    queue_degree(IDX_W'(-5));
    wait_drained();

    // Size above twelve acts as twelve
    write_reg(REG_SCALE_SIZE, OFFSETS_W'(15));
    queue_degree(IDX_W'(2047));
    queue_degree(IDX_W'(-2048));
    queue_degree(IDX_W'(13));
    wait_drained();

    // Write to the unused index must change nothing
    write_reg(REG_SPARE, rand_word());
    queue_degree(IDX_W'(100));
    wait_drained();

    // Random phases: fresh settings, then a burst of degrees
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      steady = (ph == RAND_PHASES / 2);
      if ($urandom_range(3) != 0) begin
        case ($urandom_range(3))
          0:       write_reg(REG_BASE_NOTE, rand_word() & ~OFFSETS_W'(8'h7F));
          1:       write_reg(REG_BASE_NOTE, rand_word() | OFFSETS_W'(8'h7F));
          default: write_reg(REG_BASE_NOTE, rand_word());
        endcase
      end
      if ($urandom_range(3) != 0) write_reg(REG_SCALE_SIZE, rand_word());
      if ($urandom_range(3) != 0) write_reg(REG_SCALE_OFFSETS, rand_word());
      if ($urandom_range(3) == 0) write_reg(REG_SPARE, rand_word());
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if ($urandom_range(3) == 0)
          queue_degree(IDX_W'(int'($urandom_range(80)) - 40));
        else
          queue_degree(IDX_W'($urandom));
      end
      wait_drained();
    end
    steady = 1'b0;

    // Let any stray strobe show up before judging
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("scale_degree_to_note_test: clean");
    end else begin
      $display("scale_degree_to_note_test: errors");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #500us;
    $display("scale_degree_to_note_test: errors");
    $finish;
  end

endmodule
